// ===== design/mm64_pkg.sv =====
// Shared constants and types for the MurmurHash64A stream hasher.
package mm64_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  typedef logic [63:0] word_t;

endpackage

// ===== design/mm64_mul.sv =====
// Iterative 64x64 (low half) multiply by the mix constant on one 32x32 multiplier.
module mm64_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mm64_pkg::word_t  operand_i,
  output logic             done_o,
  output mm64_pkg::word_t  result_o
);
  import mm64_pkg::*;

  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_LL,
    STEP_LH,
    STEP_HL
  } step_e;

  step_e        step_q, step_d;
  logic         done_q, done_d;
  word_t        op_q, op_d;
  word_t        acc_q, acc_d;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;

  // low64(a*M) = aL*ML + ((aL*MH + aH*ML) << 32)
  always_comb begin
    mul_a = (step_q == STEP_HL) ? op_q[63:32] : op_q[31:0];
    mul_b = (step_q == STEP_LH) ? MIX_MUL[63:32] : MIX_MUL[31:0];
    prod  = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    op_d   = op_q;
    acc_d  = acc_q;
    if (start_i) begin
      op_d   = operand_i;
      step_d = STEP_LL;
    end else begin
      unique case (step_q)
        STEP_IDLE: ;
        STEP_LL: begin
          acc_d  = prod;
          step_d = STEP_LH;
        end
        STEP_LH: begin
          acc_d[63:32] = acc_q[63:32] + prod[31:0];
          step_d       = STEP_HL;
        end
        STEP_HL: begin
          acc_d[63:32] = acc_q[63:32] + prod[31:0];
          step_d       = STEP_IDLE;
          done_d       = 1'b1;
        end
        default: step_d = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

// ===== design/murmur64a_stream_hash.sv =====
// Top level: MurmurHash64A over a stream of 64-bit little-endian words.
//
// Input stream (s_axis_*): one request per message word. tdata carries the
// word, its valid byte count and the message length; tuser flags the first
// word of a message (hash starts from seed ^ length*M), tlast the final one.
// A count of 0 mixes nothing, 1..7 is a tail word, 8 or more a full word.
// Output stream (m_axis_*): one hash per message, issued after the last word.
// Config (APB): seed at byte address 0, 64-bit data, pready tied high.
//
// Datapath: every 64-bit multiply runs on one shared 32x32 multiplier,
// three partial products. A first word adds one multiply (length*M), a
// full word takes three, a tail word one, and a last word one more for
// finalization. tready is high only between words; the design works on
// one word at a time.
// Reset clears the seed and running hash to zero and empties the output.
// A stalled receiver leaves the hash in the output register; the next
// message words are still taken and only a second finished hash waits.
module murmur64a_stream_hash (
  input  logic          clk_i,
  input  logic          rst_ni,
  // slave stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,   // data_word[63:0], valid_bytes[67:64],
                                        // total_length[98:68], zero fill above
  input  logic          s_axis_tuser,   // first_item
  input  logic          s_axis_tlast,   // last_item
  // master stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,   // hash_value[63:0]
  // config
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import mm64_pkg::*;

  localparam logic [3:0] ADDR_SEED = 4'h0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_DATA,
    ST_K1,
    ST_K2,
    ST_HMUL,
    ST_CHECK,
    ST_FIN,
    ST_OUT
  } state_e;

  state_e       state_q, state_d;
  word_t        seed_q, seed_d;
  word_t        hash_q, hash_d;
  word_t        word_q, word_d;
  logic [3:0]   count_q, count_d;
  logic         last_q, last_d;
  logic         ovalid_q, ovalid_d;
  word_t        odata_q, odata_d;

  logic         mul_start;
  word_t        mul_operand;
  logic         mul_done;
  word_t        mul_res;
  word_t        mul_mix;
  word_t        tail_word;
  logic         s_take;

  mm64_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (mul_operand),
    .done_o    (mul_done),
    .result_o  (mul_res)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_take        = s_axis_tvalid && s_axis_tready;
  assign mul_mix       = mul_res ^ (mul_res >> MIX_SHIFT);

  // keep only the low count bytes of a tail word
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      tail_word[8*b +: 8] = (4'(b) < count_q) ? word_q[8*b +: 8] : 8'h00;
    end
  end

  always_comb begin
    state_d     = state_q;
    seed_d      = seed_q;
    hash_d      = hash_q;
    word_d      = word_q;
    count_d     = count_q;
    last_d      = last_q;
    ovalid_d    = ovalid_q;
    odata_d     = odata_q;
    mul_start   = 1'b0;
    mul_operand = hash_q;

    if (psel && penable && pwrite && paddr == ADDR_SEED) seed_d = pwdata;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_take) begin
          word_d  = s_axis_tdata[63:0];
          count_d = s_axis_tdata[67:64];
          last_d  = s_axis_tlast;
          if (s_axis_tuser) begin
            mul_start   = 1'b1;
            mul_operand = {33'b0, s_axis_tdata[98:68]};
            state_d     = ST_INIT;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_INIT: begin
        if (mul_done) begin
          hash_d  = seed_q ^ mul_res;
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (count_q[3]) begin
          mul_start   = 1'b1;
          mul_operand = word_q;
          state_d     = ST_K1;
        end else if (count_q != 4'd0) begin
          mul_start   = 1'b1;
          mul_operand = hash_q ^ tail_word;
          state_d     = ST_HMUL;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_K1: begin
        if (mul_done) begin
          mul_start   = 1'b1;
          mul_operand = mul_mix;
          state_d     = ST_K2;
        end
      end
      ST_K2: begin
        if (mul_done) begin
          mul_start   = 1'b1;
          mul_operand = hash_q ^ mul_res;
          state_d     = ST_HMUL;
        end
      end
      ST_HMUL: begin
        if (mul_done) begin
          hash_d  = mul_res;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (last_q) begin
          mul_start   = 1'b1;
          mul_operand = hash_q ^ (hash_q >> MIX_SHIFT);
          state_d     = ST_FIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (mul_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        // product stays in the multiplier until the output register frees up
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = mul_mix;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      seed_q   <= '0;
      hash_q   <= '0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
    end else begin
      state_q  <= state_d;
      seed_q   <= seed_d;
      hash_q   <= hash_d;
      ovalid_q <= ovalid_d;
      odata_q  <= odata_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    count_q <= count_d;
    last_q  <= last_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign prdata        = (paddr == ADDR_SEED) ? seed_q : 64'd0;
  assign pready        = 1'b1;

endmodule
